// ===== rtl/core/cac_pkg.sv =====
// cac_pkg: shared types, widths and opcodes of the complex integer alu
// no dependencies
`timescale 1ns / 1ps

package cac_pkg;

	localparam int PW = 16;
	localparam int DW = 2 * PW + 1;
	localparam int XW = (2 * PW + 2 > 32) ? 2 * PW + 2 : 32;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_EQ  = 3'd4,
		OP_LT  = 3'd5,
		OP_GT  = 3'd6
	} op_t;

	typedef struct packed {
		op_t               op;
		logic              is_div;
		logic              is_cmp;
		logic signed [PW-1:0] ar;
		logic signed [PW-1:0] ai;
		logic signed [PW-1:0] br;
		logic signed [PW-1:0] bi;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic signed [PW-1:0] sext_part(input logic [15:0] x);
		logic signed [PW-1:0] r;
		for (int i = 0; i < PW; i++) begin
			r[i] = (i < 16) ? x[i] : x[15];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/cac_front.sv =====
// cac_front: input register, operand extraction and opcode classification
// depends on cac_pkg
`timescale 1ns / 1ps

module cac_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          op,
	input  logic [15:0]         a_re,
	input  logic [15:0]         a_im,
	input  logic [15:0]         b_re,
	input  logic [15:0]         b_im,
	input  cac_pkg::qstat_t     qstat,
	output logic                push,
	output cac_pkg::item_t      item
);
	import cac_pkg::*;

	logic  vld_s1;
	item_t item_s1;
	logic  adv;
	item_t nxt;

	assign adv      = !vld_s1 || !qstat.full;
	assign in_stall = vld_s1 && qstat.full;
	assign push     = vld_s1 && !qstat.full;
	assign item     = item_s1;

	always_comb begin
		nxt.op     = op_t'(op);
		nxt.is_div = (op_t'(op) == OP_DIV);
		nxt.is_cmp = (op_t'(op) == OP_EQ) || (op_t'(op) == OP_LT) || (op_t'(op) == OP_GT);
		nxt.ar     = sext_part(a_re);
		nxt.ai     = sext_part(a_im);
		nxt.br     = sext_part(b_re);
		nxt.bi     = sext_part(b_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			item_s1 <= nxt;
		end
	end

endmodule

// ===== rtl/core/cac_fifo.sv =====
// cac_fifo: short item queue between the front and the back
// depends on cac_pkg
`timescale 1ns / 1ps

module cac_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cac_pkg::item_t    din,
	input  logic              pop,
	output cac_pkg::item_t    dout,
	output cac_pkg::qstat_t   qstat
);
	import cac_pkg::*;

	item_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign dout        = mem_q[rd_ptr_q];
	assign qstat.full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ===== rtl/core/cac_back.sv =====
// cac_back: products, result forming, pipelined restoring divider, output register
// depends on cac_pkg
`timescale 1ns / 1ps

module cac_back (
	input  logic                clk,
	input  logic                arst_n,
	input  cac_pkg::qstat_t     qstat,
	input  cac_pkg::item_t      item,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  res_re,
	output logic signed [31:0]  res_im,
	output logic                cmp_true,
	output logic                div_zero
);
	import cac_pkg::*;

	typedef struct packed {
		logic                 vld;
		logic                 is_div;
		logic                 dz;
		logic                 cmp;
		logic                 neg_re;
		logic                 neg_im;
		logic [DW-1:0]        num_re;
		logic [DW-1:0]        num_im;
		logic [DW-1:0]        rem_re;
		logic [DW-1:0]        rem_im;
		logic [DW-1:0]        den;
		logic signed [XW-1:0] r_re;
		logic signed [XW-1:0] r_im;
	} dstage_t;

	logic en;

	// stage 1: products and simple results
	logic                   vld_s1;
	op_t                    op_s1;
	logic                   div_s1;
	logic signed [2*PW-1:0] p_rr_s1, p_ii_s1, p_ir_s1, p_ri_s1, sq_r_s1, sq_i_s1;
	logic signed [XW-1:0]   sum_re_s1, sum_im_s1, dif_re_s1, dif_im_s1;
	logic                   cmp_s1;
	logic                   cmp_nxt;

	// stage 2: numerators, divisor, non-divide results
	dstage_t st_s2;
	dstage_t nx_s2;
	logic signed [XW-1:0] e_rr, e_ii, e_ir, e_ri, n_re, n_im, d_sum;

	dstage_t sd [DW+1];

	logic signed [XW-1:0] q_re, q_im;
	logic                 out_vld_q;
	logic signed [31:0]   re_q, im_q;
	logic                 cmp_q, dz_q;

	assign en        = !out_vld_q || !out_stall;
	assign pop       = !qstat.empty && en;
	assign out_valid = out_vld_q;
	assign res_re    = re_q;
	assign res_im    = im_q;
	assign cmp_true  = cmp_q;
	assign div_zero  = dz_q;

	always_comb begin
		case (item.op)
			OP_EQ:   cmp_nxt = (item.ar == item.br) && (item.ai == item.bi);
			OP_LT:   cmp_nxt = (item.ar < item.br) && (item.ai < item.bi);
			OP_GT:   cmp_nxt = (item.ar > item.br) && (item.ai > item.bi);
			default: cmp_nxt = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (en && pop) begin
			op_s1     <= item.op;
			div_s1    <= item.is_div;
			p_rr_s1   <= (2*PW)'(item.ar) * (2*PW)'(item.br);
			p_ii_s1   <= (2*PW)'(item.ai) * (2*PW)'(item.bi);
			p_ir_s1   <= (2*PW)'(item.ai) * (2*PW)'(item.br);
			p_ri_s1   <= (2*PW)'(item.ar) * (2*PW)'(item.bi);
			sq_r_s1   <= (2*PW)'(item.br) * (2*PW)'(item.br);
			sq_i_s1   <= (2*PW)'(item.bi) * (2*PW)'(item.bi);
			sum_re_s1 <= XW'(item.ar) + XW'(item.br);
			sum_im_s1 <= XW'(item.ai) + XW'(item.bi);
			dif_re_s1 <= XW'(item.ar) - XW'(item.br);
			dif_im_s1 <= XW'(item.ai) - XW'(item.bi);
			cmp_s1    <= cmp_nxt;
		end
	end

	assign e_rr  = XW'(p_rr_s1);
	assign e_ii  = XW'(p_ii_s1);
	assign e_ir  = XW'(p_ir_s1);
	assign e_ri  = XW'(p_ri_s1);
	assign n_re  = e_rr + e_ii;
	assign n_im  = e_ir - e_ri;
	assign d_sum = XW'(sq_r_s1) + XW'(sq_i_s1);

	always_comb begin
		nx_s2        = '0;
		nx_s2.vld    = vld_s1;
		nx_s2.is_div = div_s1;
		nx_s2.neg_re = n_re[XW-1];
		nx_s2.neg_im = n_im[XW-1];
		nx_s2.num_re = n_re[XW-1] ? DW'(-n_re) : DW'(n_re);
		nx_s2.num_im = n_im[XW-1] ? DW'(-n_im) : DW'(n_im);
		nx_s2.den    = DW'(d_sum);
		nx_s2.dz     = div_s1 && (d_sum == '0);
		case (op_s1)
			OP_ADD: begin
				nx_s2.r_re = sum_re_s1;
				nx_s2.r_im = sum_im_s1;
			end
			OP_SUB: begin
				nx_s2.r_re = dif_re_s1;
				nx_s2.r_im = dif_im_s1;
			end
			OP_MUL: begin
				nx_s2.r_re = e_rr - e_ii;
				nx_s2.r_im = e_ir + e_ri;
			end
			OP_EQ, OP_LT, OP_GT: begin
				nx_s2.cmp = cmp_s1;
			end
			default: begin
				nx_s2.r_re = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s2 <= '0;
		end else if (en) begin
			st_s2 <= nx_s2;
		end
	end

	assign sd[0] = st_s2;

	// one quotient bit of each part per stage
	for (genvar k = 0; k < DW; k++) begin : g_div
		logic [DW:0]   sh_re, sh_im;
		logic          ge_re, ge_im;
		dstage_t       nx;

		assign sh_re = {sd[k].rem_re, sd[k].num_re[DW-1]};
		assign sh_im = {sd[k].rem_im, sd[k].num_im[DW-1]};
		assign ge_re = sh_re >= {1'b0, sd[k].den};
		assign ge_im = sh_im >= {1'b0, sd[k].den};

		always_comb begin
			nx        = sd[k];
			nx.rem_re = ge_re ? DW'(sh_re - {1'b0, sd[k].den}) : sh_re[DW-1:0];
			nx.rem_im = ge_im ? DW'(sh_im - {1'b0, sd[k].den}) : sh_im[DW-1:0];
			nx.num_re = {sd[k].num_re[DW-2:0], ge_re};
			nx.num_im = {sd[k].num_im[DW-2:0], ge_im};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sd[k+1] <= '0;
			end else if (en) begin
				sd[k+1] <= nx;
			end
		end
	end

	assign q_re = sd[DW].neg_re ? -$signed(XW'(sd[DW].num_re)) : $signed(XW'(sd[DW].num_re));
	assign q_im = sd[DW].neg_im ? -$signed(XW'(sd[DW].num_im)) : $signed(XW'(sd[DW].num_im));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= sd[DW].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmp_q <= sd[DW].cmp;
			dz_q  <= sd[DW].dz;
			if (sd[DW].is_div) begin
				re_q <= sd[DW].dz ? '0 : q_re[31:0];
				im_q <= sd[DW].dz ? '0 : q_im[31:0];
			end else begin
				re_q <= sd[DW].r_re[31:0];
				im_q <= sd[DW].r_im[31:0];
			end
		end
	end

endmodule

// ===== rtl/core/complex_integer_alu.sv =====
// complex_integer_alu: top level, front classifier, item queue and execution back end
// depends on cac_pkg, cac_front, cac_fifo, cac_back
`timescale 1ns / 1ps

// usage
//   input channel: in_valid / in_stall with op, a_re, a_im, b_re, b_im
//   output channel: out_valid / out_stall with res_re, res_im, cmp_true, div_zero
//   a transfer happens on a rising edge with valid high and stall low
//   every item gives exactly one result, in order
//   an item passes the input register, the queue, stages 1 and 2, the restoring
//   divider (one quotient bit per stage for both parts) and the output register
//   throughput: one item per cycle unless stalled; all operations share one pipeline
//   a four-entry queue sits between the input register and the back end
//   when out_stall and out_valid are both high the whole back end holds; the queue
//   and input register keep taking items until full, then in_stall rises
//   reset clears all valid flags and the queue; no stored state otherwise
//   divide by zero magnitude gives zero parts with div_zero set

module complex_integer_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         op,
	input  logic signed [15:0] a_re,
	input  logic signed [15:0] a_im,
	input  logic signed [15:0] b_re,
	input  logic signed [15:0] b_im,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] res_re,
	output logic signed [31:0] res_im,
	output logic               cmp_true,
	output logic               div_zero
);
	import cac_pkg::*;

	qstat_t qstat;
	logic   push;
	logic   pop;
	item_t  f_item;
	item_t  q_item;

	cac_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.a_re     (a_re),
		.a_im     (a_im),
		.b_re     (b_re),
		.b_im     (b_im),
		.qstat    (qstat),
		.push     (push),
		.item     (f_item)
	);

	cac_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (f_item),
		.pop    (pop),
		.dout   (q_item),
		.qstat  (qstat)
	);

	cac_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.item      (q_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_re    (res_re),
		.res_im    (res_im),
		.cmp_true  (cmp_true),
		.div_zero  (div_zero)
	);

`ifndef SYNTH
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_zero |-> res_re == '0 && res_im == '0)
		else $error("divide by zero with nonzero result");

	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cmp_true |-> res_re == '0 && res_im == '0 && !div_zero)
		else $error("compare result with arithmetic fields set");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue read while empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue write while full");
`endif

endmodule
